// ===== hw/rtl/range_fusion_velocity_estimator_assert.svh =====
// assertion macros shared by the range fusion velocity estimator rtl
// expects signals named clock and reset in the module that uses them
`ifndef RANGE_FUSION_VELOCITY_ESTIMATOR_ASSERT_SVH
`define RANGE_FUSION_VELOCITY_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RFVE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define RFVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rfve_pkg.sv =====
// types, constants and helpers for the range fusion velocity estimator
// no dependencies
`default_nettype none

package rfve_pkg;

   localparam int DIST_W    = 16;
   localparam int DOP_W     = 16;
   localparam int WGT_W     = 9;
   localparam int FILT_W    = 24;
   localparam int VEL_W     = 24;
   localparam int ACC_W     = 20;
   localparam int DB_W      = 16;
   localparam int HOLD_W    = 8;
   localparam int GAIN_W    = 16;
   localparam int LIM_W     = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUM_W   = 36;
   localparam int DELTA_W = FILT_W + 1;
   localparam int DIFF_W  = VEL_W + 1;
   localparam int RAW_W   = 34;

   localparam int ROUND_HALF       = 128;
   localparam int TICKS_PER_SECOND = 100;

   localparam logic [WGT_W-1:0]  Q8_ONE       = 9'd256;
   localparam logic [DIST_W-1:0] DIST_INVALID = 16'hFFFF;
   localparam logic [VEL_W-1:0]  VEL_MAX      = 24'h7FFFFF;

   localparam logic [WGT_W-1:0]  DIST_SMOOTH_RST  = 9'd179;
   localparam logic [DB_W-1:0]   SIGN_BAND_RST    = 16'd512;
   localparam logic [HOLD_W-1:0] SIGN_HOLD_RST    = 8'd50;
   localparam logic [GAIN_W-1:0] DOP_GAIN_RST     = 16'd1040;
   localparam logic [LIM_W-1:0]  ACCEL_LIMIT_RST  = 19'd327680;
   localparam logic [WGT_W-1:0]  ACCEL_SMOOTH_RST = 9'd179;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIST_SMOOTH  = 3'd0,
      CSR_SIGN_BAND    = 3'd1,
      CSR_SIGN_HOLD    = 3'd2,
      CSR_DOP_GAIN     = 3'd3,
      CSR_ACCEL_LIMIT  = 3'd4,
      CSR_ACCEL_SMOOTH = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_ULTRA = 2'd1,
      KIND_LIDAR = 2'd2,
      KIND_BOTH  = 2'd3
   } dist_kind_type;

   typedef enum logic [1:0] {
      SIGN_NONE    = 2'd0,
      SIGN_CLOSING = 2'd1,
      SIGN_OPENING = 2'd2
   } sign_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLEND0,
      ST_BLEND1,
      ST_FILT0,
      ST_FILT1,
      ST_SIGN,
      ST_VEL,
      ST_DIFF,
      ST_RAW,
      ST_ACC0,
      ST_ACC1
   } st_type;

   typedef struct packed {
      logic [WGT_W-1:0]  distance_smoothing;
      logic [DB_W-1:0]   sign_deadband;
      logic [HOLD_W-1:0] sign_hold_limit;
      logic [GAIN_W-1:0] doppler_gain;
      logic [LIM_W-1:0]  accel_limit;
      logic [WGT_W-1:0]  accel_smoothing;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0] ultra_cm;
      logic [DIST_W-1:0] lidar_cm;
      logic [DOP_W-1:0]  doppler_scaled;
      logic [WGT_W-1:0]  weight;
      dist_kind_type     kind;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // weights above one saturate at one
   function automatic logic [WGT_W-1:0] cap_one(input logic [WGT_W-1:0] w);
      return (w > Q8_ONE) ? Q8_ONE : w;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rfve_chan_if.sv =====
// request, response and register write channels of the estimator
// depends on rfve_pkg
`default_nettype none

interface rfve_req_if;
   import rfve_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] ultra_cm;
   logic [DIST_W-1:0] lidar_cm;
   logic [DOP_W-1:0]  doppler_scaled;
   logic [WGT_W-1:0]  fusion_weight;

   modport source (output valid, ultra_cm, lidar_cm, doppler_scaled, fusion_weight,
                   input ready);
   modport sink   (input valid, ultra_cm, lidar_cm, doppler_scaled, fusion_weight,
                   output ready);
endinterface

interface rfve_rsp_if;
   import rfve_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DIST_W-1:0]        fused_cm;
   logic signed [VEL_W-1:0]  rel_velocity;
   logic signed [ACC_W-1:0]  rel_accel;

   modport source (output valid, fused_cm, rel_velocity, rel_accel, input ready);
   modport sink   (input valid, fused_cm, rel_velocity, rel_accel, output ready);
endinterface

interface rfve_csr_if;
   import rfve_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, idx, data, input ready);
   modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rfve_queue.sv =====
// short request queue between the classifying front and the sequencer
// depends on rfve_pkg and the assertion macro header
`default_nettype none
`include "range_fusion_velocity_estimator_assert.svh"

module rfve_queue #(
   parameter int Depth = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rfve_pkg::item_type    push_item,
   input  logic                  pop,
   output rfve_pkg::item_type    pop_item,
   output rfve_pkg::q_status_type q_status
);
   import rfve_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item       = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CntW'(Depth));
   assign q_status.empty = (count_ff == '0);

   `RFVE_ASSERT_NOW(a_q_push_room, push, !q_status.full, "push into a full queue")
   `RFVE_ASSERT_NOW(a_q_pop_data, pop, !q_status.empty, "pop from an empty queue")
   `RFVE_ASSERT_NEXT(a_q_holds_push, push && !pop, !q_status.empty, "pushed request lost")

endmodule

`default_nettype wire

// ===== hw/rtl/rfve_front.sv =====
// front end: takes requests, checks the two distances and caps the weight
// depends on rfve_pkg and rfve_chan_if
`default_nettype none

module rfve_front (
   rfve_req_if.sink               req_chan,
   input  rfve_pkg::q_status_type q_status,
   output logic                   q_push,
   output rfve_pkg::item_type     q_item
);
   import rfve_pkg::*;

   logic ultra_ok;
   logic lidar_ok;

   assign ultra_ok = (req_chan.ultra_cm != '0) && (req_chan.ultra_cm != DIST_INVALID);
   assign lidar_ok = (req_chan.lidar_cm != '0) && (req_chan.lidar_cm != DIST_INVALID);

   assign req_chan.ready = !q_status.full;
   assign q_push         = req_chan.valid && !q_status.full;

   always_comb begin
      q_item.ultra_cm       = req_chan.ultra_cm;
      q_item.lidar_cm       = req_chan.lidar_cm;
      q_item.doppler_scaled = req_chan.doppler_scaled;
      q_item.weight         = cap_one(req_chan.fusion_weight);
      case ({lidar_ok, ultra_ok})
         2'b11:   q_item.kind = KIND_BOTH;
         2'b10:   q_item.kind = KIND_LIDAR;
         2'b01:   q_item.kind = KIND_ULTRA;
         default: q_item.kind = KIND_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rfve_back.sv =====
// back end: sequencer with one shared multiplier, filter and sign state, result register
// depends on rfve_pkg, rfve_chan_if and the assertion macro header
`default_nettype none
`include "range_fusion_velocity_estimator_assert.svh"

module rfve_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rfve_pkg::cfg_type      cfg,
   input  rfve_pkg::q_status_type q_status,
   input  rfve_pkg::item_type     q_item,
   output logic                   q_pop,
   rfve_rsp_if.source             rsp_chan
);
   import rfve_pkg::*;

   st_type                    state_ff, state_in;
   item_type                  item_ff, item_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [FILT_W-1:0]         now_ff, now_in;
   logic [FILT_W-1:0]         smooth_ff, smooth_in;
   logic [FILT_W-1:0]         filt_ff, filt_in;
   logic [FILT_W-1:0]         prev_filt_ff, prev_filt_in;
   logic                      awaiting_ff, awaiting_in;
   sign_type                  sign_ff, sign_in;
   logic [HOLD_W-1:0]         hold_ff, hold_in;
   logic [DIST_W-1:0]         pub_ff, pub_in;
   logic [VEL_W-1:0]          mag_ff, mag_in;
   logic signed [VEL_W-1:0]   vel_ff, vel_in;
   logic signed [VEL_W-1:0]   prev_vel_ff, prev_vel_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      active_ff, active_in;
   logic signed [ACC_W-1:0]   raw_ff, raw_in;
   logic signed [ACC_W-1:0]   prev_acc_ff, prev_acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]         rsp_fused_ff, rsp_fused_in;
   logic signed [VEL_W-1:0]   rsp_vel_ff, rsp_vel_in;
   logic signed [ACC_W-1:0]   rsp_acc_ff, rsp_acc_in;

   logic                      out_free;
   logic                      commit;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [WGT_W-1:0]          dist_w;
   logic [WGT_W-1:0]          accel_w;
   logic signed [SUM_W-1:0]   blend;
   logic signed [SUM_W-1:0]   sum_rnd;
   logic signed [SUM_W-1:0]   prod_rnd;
   logic signed [DELTA_W-1:0] delta;
   logic signed [DELTA_W-1:0] band;
   logic signed [VEL_W-1:0]   vel_sel;
   logic signed [RAW_W-1:0]   raw_wide;
   logic signed [RAW_W-1:0]   lim_wide;
   logic signed [ACC_W-1:0]   acc_val;

   // round half up to whole cm
   function automatic logic [DIST_W-1:0] round_cm(input logic [FILT_W-1:0] f);
      logic [FILT_W:0] t;
      t = (FILT_W + 1)'(f) + (FILT_W + 1)'(ROUND_HALF);
      return t[FILT_W-1:8];
   endfunction

   assign dist_w   = cap_one(cfg.distance_smoothing);
   assign accel_w  = cap_one(cfg.accel_smoothing);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // shared multiplier, product used by the accumulate, round and acceleration clamp paths
   assign prod     = mul_a * mul_b;
   assign blend    = sum_ff + $signed(prod[SUM_W-1:0]);
   assign sum_rnd  = blend + SUM_W'(ROUND_HALF);
   assign prod_rnd = $signed(prod[SUM_W-1:0]) + SUM_W'(ROUND_HALF);
   assign acc_val  = $signed(sum_rnd[8 +: ACC_W]);

   assign delta    = $signed(DELTA_W'(smooth_ff)) - $signed(DELTA_W'(prev_filt_ff));
   assign band     = $signed(DELTA_W'(cfg.sign_deadband));
   assign vel_sel  = (sign_ff == SIGN_CLOSING) ? $signed(mag_ff) : -$signed(mag_ff);
   assign raw_wide = $signed(prod[RAW_W-1:0]);
   assign lim_wide = $signed(RAW_W'(cfg.accel_limit));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   state_in = q_status.empty ? ST_IDLE : ST_BLEND0;
         ST_BLEND0: state_in = ST_BLEND1;
         ST_BLEND1: state_in = ST_FILT0;
         ST_FILT0:  state_in = ST_FILT1;
         ST_FILT1:  state_in = ST_SIGN;
         ST_SIGN:   state_in = ST_VEL;
         ST_VEL:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_RAW;
         ST_RAW:    state_in = ST_ACC0;
         ST_ACC0:   state_in = ST_ACC1;
         ST_ACC1:   state_in = out_free ? ST_IDLE : ST_ACC1;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: pop, commit and multiplier operands
   always_comb begin
      q_pop  = 1'b0;
      commit = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_IDLE:   q_pop = !q_status.empty;
         ST_BLEND0: begin
            mul_a = MUL_A_W'(item_ff.lidar_cm);
            mul_b = MUL_B_W'(item_ff.weight);
         end
         ST_BLEND1: begin
            mul_a = MUL_A_W'(item_ff.ultra_cm);
            mul_b = MUL_B_W'(Q8_ONE - item_ff.weight);
         end
         ST_FILT0: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = MUL_B_W'(dist_w);
         end
         ST_FILT1: begin
            mul_a = MUL_A_W'(now_ff);
            mul_b = MUL_B_W'(Q8_ONE - dist_w);
         end
         ST_VEL: begin
            mul_a = MUL_A_W'(item_ff.doppler_scaled);
            mul_b = MUL_B_W'(cfg.doppler_gain);
         end
         ST_RAW: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = MUL_B_W'(TICKS_PER_SECOND);
         end
         ST_ACC0: begin
            mul_a = MUL_A_W'(prev_acc_ff);
            mul_b = MUL_B_W'(accel_w);
         end
         ST_ACC1: begin
            mul_a  = MUL_A_W'(raw_ff);
            mul_b  = MUL_B_W'(Q8_ONE - accel_w);
            commit = out_free;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      item_in      = item_ff;
      sum_in       = sum_ff;
      now_in       = now_ff;
      smooth_in    = smooth_ff;
      filt_in      = filt_ff;
      prev_filt_in = prev_filt_ff;
      awaiting_in  = awaiting_ff;
      sign_in      = sign_ff;
      hold_in      = hold_ff;
      pub_in       = pub_ff;
      mag_in       = mag_ff;
      vel_in       = vel_ff;
      diff_in      = diff_ff;
      active_in    = active_ff;
      raw_in       = raw_ff;
      prev_vel_in  = prev_vel_ff;
      prev_acc_in  = prev_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_fused_in = rsp_fused_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_acc_in   = rsp_acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               item_in = q_item;
            end
         end
         ST_BLEND0: sum_in = $signed(prod[SUM_W-1:0]);
         ST_BLEND1: begin
            case (item_ff.kind)
               KIND_BOTH:  now_in = blend[FILT_W-1:0];
               KIND_LIDAR: now_in = {item_ff.lidar_cm, 8'h00};
               KIND_ULTRA: now_in = {item_ff.ultra_cm, 8'h00};
               default:    now_in = '0;
            endcase
         end
         ST_FILT0: sum_in = $signed(prod[SUM_W-1:0]);
         ST_FILT1: smooth_in = sum_rnd[8 +: FILT_W];
         ST_SIGN: begin
            if (item_ff.kind == KIND_NONE) begin
               // nothing usable: restart the filter
               awaiting_in  = 1'b1;
               filt_in      = '0;
               prev_filt_in = '0;
               sign_in      = SIGN_NONE;
               hold_in      = '0;
               pub_in       = DIST_INVALID;
            end else if (awaiting_ff) begin
               // first good sample loads the filter
               awaiting_in  = 1'b0;
               filt_in      = now_ff;
               prev_filt_in = now_ff;
               sign_in      = SIGN_NONE;
               hold_in      = '0;
               pub_in       = round_cm(now_ff);
            end else begin
               filt_in      = smooth_ff;
               prev_filt_in = smooth_ff;
               pub_in       = round_cm(smooth_ff);
               if (delta <= -band) begin
                  sign_in = SIGN_CLOSING;
                  hold_in = '0;
               end else if (delta >= band) begin
                  sign_in = SIGN_OPENING;
                  hold_in = '0;
               end else if (hold_ff < cfg.sign_hold_limit) begin
                  hold_in = hold_ff + 1'b1;
               end else begin
                  sign_in = SIGN_NONE;
               end
            end
         end
         ST_VEL: begin
            if (prod_rnd[SUM_W-1:8] > (SUM_W - 8)'(VEL_MAX)) begin
               mag_in = VEL_MAX;
            end else begin
               mag_in = prod_rnd[8 +: VEL_W];
            end
         end
         ST_DIFF: begin
            active_in = (pub_ff != DIST_INVALID) && (sign_ff != SIGN_NONE);
            vel_in    = ((pub_ff != DIST_INVALID) && (sign_ff != SIGN_NONE)) ? vel_sel : '0;
            diff_in   = DIFF_W'(vel_sel) - DIFF_W'(prev_vel_ff);
         end
         ST_RAW: begin
            if (raw_wide > lim_wide) begin
               raw_in = ACC_W'(lim_wide);
            end else if (raw_wide < -lim_wide) begin
               raw_in = ACC_W'(-lim_wide);
            end else begin
               raw_in = ACC_W'(raw_wide);
            end
         end
         ST_ACC0: sum_in = $signed(prod[SUM_W-1:0]);
         ST_ACC1: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_fused_in = pub_ff;
               rsp_vel_in   = vel_ff;
               rsp_acc_in   = active_ff ? acc_val : '0;
               prev_vel_in  = vel_ff;
               prev_acc_in  = active_ff ? acc_val : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filt_ff      <= '0;
         prev_filt_ff <= '0;
         awaiting_ff  <= 1'b1;
         sign_ff      <= SIGN_NONE;
         hold_ff      <= '0;
         pub_ff       <= DIST_INVALID;
         prev_vel_ff  <= '0;
         prev_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         prev_filt_ff <= prev_filt_in;
         awaiting_ff  <= awaiting_in;
         sign_ff      <= sign_in;
         hold_ff      <= hold_in;
         pub_ff       <= pub_in;
         prev_vel_ff  <= prev_vel_in;
         prev_acc_ff  <= prev_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      sum_ff       <= sum_in;
      now_ff       <= now_in;
      smooth_ff    <= smooth_in;
      mag_ff       <= mag_in;
      vel_ff       <= vel_in;
      diff_ff      <= diff_in;
      active_ff    <= active_in;
      raw_ff       <= raw_in;
      rsp_fused_ff <= rsp_fused_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fused_cm     = rsp_fused_ff;
   assign rsp_chan.rel_velocity = rsp_vel_ff;
   assign rsp_chan.rel_accel    = rsp_acc_ff;

   `RFVE_ASSERT_NOW(a_vel_needs_dist, rsp_valid_ff && (rsp_vel_ff != '0),
      rsp_fused_ff != DIST_INVALID, "velocity reported without a distance")
   `RFVE_ASSERT_NOW(a_acc_needs_dist, rsp_valid_ff && (rsp_acc_ff != '0),
      rsp_fused_ff != DIST_INVALID, "acceleration reported without a distance")
   `RFVE_ASSERT_NOW(a_awaiting_clear, awaiting_ff,
      (sign_ff == SIGN_NONE) && (hold_ff == '0), "sign state left over while awaiting")

endmodule

`default_nettype wire

// ===== hw/rtl/range_fusion_velocity_estimator.sv =====
// range fusion velocity estimator top level: register file, front, queue and sequencer
// depends on rfve_pkg, rfve_chan_if, rfve_front, rfve_queue and rfve_back
// a popped request steps through the blend, filter, sign, velocity, diff, raw and
// accumulate states into the output register; one shared multiplier serves eight
// products, one request at a time; the queue takes up to QueueDepth requests meanwhile
// reset (synchronous): registers to defaults, filter awaiting its first sample, queue empty
`default_nettype none

module range_fusion_velocity_estimator #(
   parameter int QueueDepth = 2
) (
   input  logic        clock,
   input  logic        reset,
   rfve_req_if.sink    req_chan,
   rfve_rsp_if.source  rsp_chan,
   rfve_csr_if.sink    csr_chan
);
   import rfve_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   item_type     push_item;
   item_type     pop_item;
   logic         push;
   logic         pop;

   // register writes are always taken; unknown indexes fall through
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.idx)
            CSR_DIST_SMOOTH:  cfg_in.distance_smoothing = csr_chan.data[WGT_W-1:0];
            CSR_SIGN_BAND:    cfg_in.sign_deadband      = csr_chan.data[DB_W-1:0];
            CSR_SIGN_HOLD:    cfg_in.sign_hold_limit    = csr_chan.data[HOLD_W-1:0];
            CSR_DOP_GAIN:     cfg_in.doppler_gain       = csr_chan.data[GAIN_W-1:0];
            CSR_ACCEL_LIMIT:  cfg_in.accel_limit        = csr_chan.data[LIM_W-1:0];
            CSR_ACCEL_SMOOTH: cfg_in.accel_smoothing    = csr_chan.data[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_smoothing <= DIST_SMOOTH_RST;
         cfg_ff.sign_deadband      <= SIGN_BAND_RST;
         cfg_ff.sign_hold_limit    <= SIGN_HOLD_RST;
         cfg_ff.doppler_gain       <= DOP_GAIN_RST;
         cfg_ff.accel_limit        <= ACCEL_LIMIT_RST;
         cfg_ff.accel_smoothing    <= ACCEL_SMOOTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accepts a request, flags the usable distances, caps the weight
   rfve_front u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (push),
      .q_item   (push_item)
   );

   // decouples acceptance from the multi-cycle sequencer
   rfve_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // back: blend, filter, closing sign, velocity and smoothed acceleration
   rfve_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .q_item   (pop_item),
      .q_pop    (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== bench/tb_range_fusion_velocity_estimator.sv =====
// self-checking bench for the range fusion velocity estimator: directed and track-shaped
// random requests, a tracking predictor and an in-order result checker
// depends on rfve_pkg, rfve_chan_if and the estimator rtl
module tb_range_fusion_velocity_estimator;
   timeunit 1ns;
   timeprecision 1ps;

   import rfve_pkg::*;

   localparam longint UNITY_Q8 = 256;
   // indexes past the last register, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [DIST_W-1:0] ultra_cm;
      logic [DIST_W-1:0] lidar_cm;
      logic [DOP_W-1:0]  doppler_scaled;
      logic [WGT_W-1:0]  fusion_weight;
   } range_tick_type;

   typedef struct packed {
      logic [DIST_W-1:0]       fused_cm;
      logic signed [VEL_W-1:0] rel_velocity;
      logic signed [ACC_W-1:0] rel_accel;
   } track_out_type;

   logic clock;
   logic reset;

   rfve_req_if req_chan ();
   rfve_rsp_if rsp_chan ();
   rfve_csr_if csr_chan ();

   range_fusion_velocity_estimator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // requests waiting for the driver and results waiting for the checker
   range_tick_type pending_ticks[$];
   track_out_type  expected_tracks[$];
   range_tick_type offered_tick;

   // register copy, follows every accepted register write
   cfg_type tracked_cfg = '{DIST_SMOOTH_RST, SIGN_BAND_RST, SIGN_HOLD_RST,
                            DOP_GAIN_RST, ACCEL_LIMIT_RST, ACCEL_SMOOTH_RST};

   // tracker state mirrored from the block
   bit       awaiting_first;
   longint   filt_q8;
   longint   prev_filt_q8;
   sign_type closing;
   longint   hold_ticks;
   longint   prev_vel;
   longint   prev_acc;
   logic [DIST_W-1:0] shown_cm;

   int requests_accepted = 0;
   int results_checked   = 0;
   int register_writes   = 0;
   int failures          = 0;
   bit idling_on         = 1'b1;
   int send_gap          = 0;
   int ready_gap         = 0;
   int rsp_hold_left;
   bit rsp_hold_armed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // weights above one act as one
   function automatic longint clip_unity(input longint w);
      return (w > UNITY_Q8) ? UNITY_Q8 : w;
   endfunction

   // add a half and floor the division by 256, negative values included
   function automatic longint round_half_up(input longint x);
      return (x + 128) >>> 8;
   endfunction

   function automatic int clamp_cm(input int v);
      return (v < 1) ? 1 : ((v > 65534) ? 65534 : v);
   endfunction

   task automatic predict_track(input range_tick_type t, output track_out_type r);
      longint ultra, lidar, dop, wgt, s, sa, now_q8, delta, band, mag, raw, vel, acc;
      bit ultra_ok, lidar_ok;
      ultra = longint'(t.ultra_cm);
      lidar = longint'(t.lidar_cm);
      dop   = longint'(t.doppler_scaled);
      wgt   = clip_unity(longint'(t.fusion_weight));
      ultra_ok = (t.ultra_cm != 16'd0) && (t.ultra_cm != DIST_INVALID);
      lidar_ok = (t.lidar_cm != 16'd0) && (t.lidar_cm != DIST_INVALID);
      vel = 0;
      acc = 0;
      if (ultra_ok || lidar_ok) begin
         if (ultra_ok && lidar_ok) now_q8 = wgt * lidar + (UNITY_Q8 - wgt) * ultra;
         else if (lidar_ok) now_q8 = lidar * UNITY_Q8;
         else now_q8 = ultra * UNITY_Q8;
         if (awaiting_first) begin
            // first sample loads the filter outright
            filt_q8        = now_q8;
            prev_filt_q8   = now_q8;
            awaiting_first = 1'b0;
            closing        = SIGN_NONE;
            hold_ticks     = 0;
         end else begin
            s = clip_unity(longint'(tracked_cfg.distance_smoothing));
            filt_q8 = round_half_up(s * filt_q8 + (UNITY_Q8 - s) * now_q8);
            delta = filt_q8 - prev_filt_q8;
            band  = longint'(tracked_cfg.sign_deadband);
            if (delta <= -band) begin
               closing    = SIGN_CLOSING;
               hold_ticks = 0;
            end else if (delta >= band) begin
               closing    = SIGN_OPENING;
               hold_ticks = 0;
            end else if (hold_ticks < longint'(tracked_cfg.sign_hold_limit)) begin
               hold_ticks++;
            end else begin
               closing = SIGN_NONE;
            end
            prev_filt_q8 = filt_q8;
         end
         shown_cm = DIST_W'((filt_q8 + 128) >>> 8);
      end else begin
         awaiting_first = 1'b1;
         filt_q8        = 0;
         prev_filt_q8   = 0;
         closing        = SIGN_NONE;
         hold_ticks     = 0;
         shown_cm       = DIST_INVALID;
      end
      if (shown_cm != DIST_INVALID && closing != SIGN_NONE) begin
         sa  = clip_unity(longint'(tracked_cfg.accel_smoothing));
         mag = round_half_up(dop * longint'(tracked_cfg.doppler_gain));
         if (mag > longint'(VEL_MAX)) mag = longint'(VEL_MAX);
         vel = (closing == SIGN_CLOSING) ? mag : -mag;
         raw = (vel - prev_vel) * longint'(TICKS_PER_SECOND);
         if (raw > longint'(tracked_cfg.accel_limit)) raw = longint'(tracked_cfg.accel_limit);
         if (raw < -longint'(tracked_cfg.accel_limit)) raw = -longint'(tracked_cfg.accel_limit);
         acc = round_half_up(sa * prev_acc + (UNITY_Q8 - sa) * raw);
      end
      prev_vel = vel;
      prev_acc = acc;
      r.fused_cm     = shown_cm;
      r.rel_velocity = vel[VEL_W-1:0];
      r.rel_accel    = acc[ACC_W-1:0];
   endtask

   // request driver: predicts each accepted request, then offers the next one
   always @(posedge clock) begin
      track_out_type predicted;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       = 0;
         awaiting_first = 1'b1;
         filt_q8        = 0;
         prev_filt_q8   = 0;
         closing        = SIGN_NONE;
         hold_ticks     = 0;
         prev_vel       = 0;
         prev_acc       = 0;
         shown_cm       = DIST_INVALID;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_track(offered_tick, predicted);
            expected_tracks.push_back(predicted);
            requests_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0 || pending_ticks.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_chan.valid <= 1'b0;
            end else begin
               offered_tick = pending_ticks.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.ultra_cm       <= offered_tick.ultra_cm;
               req_chan.lidar_cm       <= offered_tick.lidar_cm;
               req_chan.doppler_scaled <= offered_tick.doppler_scaled;
               req_chan.fusion_weight  <= offered_tick.fusion_weight;
               // idle burst after this request
               if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
            end
         end
      end
   end

   // long receiver hold-off, once, after 150 accepted requests
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left  <= 0;
         rsp_hold_armed <= 1'b1;
      end else if (rsp_hold_armed && requests_accepted >= 150) begin
         rsp_hold_left  <= 200;
         rsp_hold_armed <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   // result monitor: in-order compare against the oldest prediction
   always @(posedge clock) begin
      track_out_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tracks.size() == 0) begin
               $error("result with no request outstanding: fused_cm %0d", rsp_chan.fused_cm);
               failures++;
            end else begin
               want = expected_tracks.pop_front();
               results_checked++;
               if (rsp_chan.fused_cm !== want.fused_cm) begin
                  $error("fused_cm: expected %0d, actual %0d", want.fused_cm, rsp_chan.fused_cm);
                  failures++;
               end
               if (rsp_chan.rel_velocity !== want.rel_velocity) begin
                  $error("rel_velocity: expected %0d, actual %0d",
                         want.rel_velocity, rsp_chan.rel_velocity);
                  failures++;
               end
               if (rsp_chan.rel_accel !== want.rel_accel) begin
                  $error("rel_accel: expected %0d, actual %0d",
                         want.rel_accel, rsp_chan.rel_accel);
                  failures++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 6) == 0) ready_gap = $urandom_range(1, 5);
         end
      end
   end

   task automatic queue_tick(input int ultra, input int lidar, input int dop, input int wgt);
      range_tick_type t;
      t.ultra_cm       = DIST_W'(ultra);
      t.lidar_cm       = DIST_W'(lidar);
      t.doppler_scaled = DOP_W'(dop);
      t.fusion_weight  = WGT_W'(wgt);
      pending_ticks.push_back(t);
   endtask

   // mostly plausible target tracks, with sensor dropouts, gaps and raw noise mixed in
   task automatic queue_random_ticks(input int count);
      int queued, pick, seg_len, track_cm, step, dop, ultra, lidar;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            seg_len  = $urandom_range(4, 40);
            track_cm = $urandom_range(100, 65000);
            // some tracks barely move so the hold timeout gets exercised
            if ($urandom_range(0, 3) == 0) step = $urandom_range(0, 6) - 3;
            else step = $urandom_range(0, 600) - 300;
            dop = $urandom_range(0, 65535);
            for (int i = 0; i < seg_len; i++) begin
               track_cm = clamp_cm(track_cm + step);
               ultra = clamp_cm(track_cm + $urandom_range(0, 40) - 20);
               lidar = clamp_cm(track_cm + $urandom_range(0, 40) - 20);
               // single sensor dropout
               if ($urandom_range(0, 11) == 0) ultra = $urandom_range(0, 1) ? 65535 : 0;
               else if ($urandom_range(0, 11) == 0) lidar = $urandom_range(0, 1) ? 65535 : 0;
               dop = (dop + $urandom_range(0, 200) - 100) & 16'hFFFF;
               queue_tick(ultra, lidar, dop, $urandom_range(0, 511));
            end
            queued += seg_len;
         end else if (pick == 7) begin
            seg_len = $urandom_range(1, 3);
            for (int i = 0; i < seg_len; i++)
               queue_tick($urandom_range(0, 1) ? 65535 : 0, $urandom_range(0, 1) ? 65535 : 0,
                          $urandom_range(0, 65535), $urandom_range(0, 511));
            queued += seg_len;
         end else begin
            seg_len = $urandom_range(1, 4);
            for (int i = 0; i < seg_len; i++)
               queue_tick($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 511));
            queued += seg_len;
         end
      end
   endtask

   // one register write, valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.idx   <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_DIST_SMOOTH:  tracked_cfg.distance_smoothing = value[WGT_W-1:0];
         CSR_SIGN_BAND:    tracked_cfg.sign_deadband      = value[DB_W-1:0];
         CSR_SIGN_HOLD:    tracked_cfg.sign_hold_limit    = value[HOLD_W-1:0];
         CSR_DOP_GAIN:     tracked_cfg.doppler_gain       = value[GAIN_W-1:0];
         CSR_ACCEL_LIMIT:  tracked_cfg.accel_limit        = value[LIM_W-1:0];
         CSR_ACCEL_SMOOTH: tracked_cfg.accel_smoothing    = value[WGT_W-1:0];
         default: ;
      endcase
      register_writes++;
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] smooth, input logic [CSR_DATA_W-1:0] band,
                                input logic [CSR_DATA_W-1:0] hold, input logic [CSR_DATA_W-1:0] gain,
                                input logic [CSR_DATA_W-1:0] limit,
                                input logic [CSR_DATA_W-1:0] acc_smooth);
      write_reg(CSR_DIST_SMOOTH, smooth);
      write_reg(CSR_SIGN_BAND, band);
      write_reg(CSR_SIGN_HOLD, hold);
      write_reg(CSR_DOP_GAIN, gain);
      write_reg(CSR_ACCEL_LIMIT, limit);
      write_reg(CSR_ACCEL_SMOOTH, acc_smooth);
      csr_chan.valid <= 1'b0;
   endtask

   // wait for the block to drain, then give it its latency again
   task automatic drain();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_chan.valid || expected_tracks.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_chan.valid          <= 1'b0;
      csr_chan.idx            <= '0;
      csr_chan.data           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed part at reset settings
      queue_tick(0, 65535, 0, 0);            // nothing valid straight after reset
      queue_tick(65535, 0, 65535, 511);
      queue_tick(5000, 0, 1200, 100);        // ultrasonic alone loads the filter
      queue_tick(65535, 5200, 1200, 100);    // lidar alone
      queue_tick(5000, 5100, 1200, 0);       // blend, all ultrasonic
      queue_tick(5000, 5100, 1200, 256);     // blend, all lidar
      queue_tick(5000, 5100, 1200, 511);     // weight above one
      for (int i = 0; i < 6; i++) queue_tick(4800 - 60 * i, 4790 - 60 * i, 65535, 128);
      for (int i = 0; i < 6; i++) queue_tick(4500 + 80 * i, 4510 + 80 * i, 300, 300);
      queue_tick(1, 65534, 0, 256);          // distance extremes
      queue_tick(65534, 1, 65535, 0);
      queue_tick(0, 0, 777, 50);             // gap drops the track
      queue_tick(3000, 3000, 500, 128);      // fresh first sample after the gap
      drain();

      // reset values written back, plus writes to unused indexes
      write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      load_settings(CSR_DATA_W'(DIST_SMOOTH_RST), CSR_DATA_W'(SIGN_BAND_RST),
                    CSR_DATA_W'(SIGN_HOLD_RST), CSR_DATA_W'(DOP_GAIN_RST),
                    CSR_DATA_W'(ACCEL_LIMIT_RST), CSR_DATA_W'(ACCEL_SMOOTH_RST));
      queue_random_ticks(106);
      drain();

      // low extremes: no smoothing, zero deadband, instant clear, velocity saturates
      load_settings(CSR_DATA_W'(0), CSR_DATA_W'(0), CSR_DATA_W'(0), CSR_DATA_W'(65535),
                    CSR_DATA_W'(524287), CSR_DATA_W'(0));
      queue_random_ticks(106);
      drain();

      // high extremes: frozen filter, widest deadband, no gain, no acceleration
      load_settings(CSR_DATA_W'(256), CSR_DATA_W'(65535), CSR_DATA_W'(255), CSR_DATA_W'(0),
                    CSR_DATA_W'(0), CSR_DATA_W'(256));
      queue_random_ticks(106);
      drain();

      // out-of-width data is masked by the register width
      load_settings(19'h7FFFF, CSR_DATA_W'($urandom_range(0, 4000)),
                    {11'h7FF, 8'($urandom_range(0, 10))},
                    {3'b111, 16'($urandom)}, CSR_DATA_W'($urandom_range(0, 524287)),
                    19'h7FFFF);
      queue_random_ticks(106);
      drain();

      // plausible settings, sender and receiver run flat out
      idling_on = 1'b0;
      load_settings(CSR_DATA_W'($urandom_range(100, 250)), CSR_DATA_W'($urandom_range(0, 1500)),
                    CSR_DATA_W'($urandom_range(1, 60)), CSR_DATA_W'($urandom_range(500, 3000)),
                    CSR_DATA_W'($urandom_range(1000, 524287)),
                    CSR_DATA_W'($urandom_range(0, 256)));
      queue_random_ticks(106);
      drain();

      if (expected_tracks.size() != 0) begin
         $error("%0d results never arrived", expected_tracks.size());
         failures++;
      end
      $display("checked %0d results against %0d requests over six register settings (%0d writes)",
               results_checked, requests_accepted, register_writes);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog well past the slowest legal run
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
